// File: hdl/fbpa_pkg.sv
package fbpa_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int BUMP_W     = $clog2(NUM_BLOCKS + 1);
  localparam int RANGE_W    = ((BUMP_W > IDX_W) ? BUMP_W : IDX_W) + 1;
  localparam int LINK_DEPTH = 1 << IDX_W;
  localparam int LINK_W     = IDX_W + 1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes on the input channel
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_FAILED = 1'b1;

  // Request class as decided by the front
  typedef enum logic [1:0] {
    REQ_ALLOC,
    REQ_FREE,
    REQ_IGNORE
  } req_kind_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [IDX_W-1:0] index;
  } req_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

endpackage

// File: hdl/fbpa_front.sv
module fbpa_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [fbpa_pkg::IDX_W-1:0] free_index,
  output fbpa_pkg::queue_head_t     head,
  input  logic                      pop
);
  import fbpa_pkg::*;

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;
  req_t              req_in;

  // Classify the incoming item
  always_comb begin
    req_in.index = free_index;
    if (op == OP_ALLOC) begin
      req_in.kind = REQ_ALLOC;
    end else if (RANGE_W'(free_index) < RANGE_W'(NUM_BLOCKS)) begin
      req_in.kind = REQ_FREE;
    end else begin
      req_in.kind = REQ_IGNORE;
    end
  end

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.req   = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/fbpa_back.sv
module fbpa_back (
  input  logic                       clk,
  input  logic                       rst,
  input  fbpa_pkg::queue_head_t      head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fbpa_pkg::IDX_W-1:0] block_index,
  output logic                       status
);
  import fbpa_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_LINK
  } state_t;

  state_t            state;
  logic [BUMP_W-1:0] bump_remaining;
  logic [BUMP_W-1:0] bump_dec;
  logic [IDX_W-1:0]  list_head;
  logic              list_nonempty;

  logic [LINK_W-1:0] link_mem [LINK_DEPTH];
  logic [LINK_W-1:0] link_rdata;

  logic slot_free;
  logic issue;
  logic is_alloc;
  logic bump_empty;
  logic do_push;
  logic do_list_pop;

  // Issue decision
  assign slot_free   = !out_valid || !out_stall;
  assign issue       = (state == ST_RUN) && head.valid && slot_free;
  assign pop         = issue;
  assign is_alloc    = (head.req.kind == REQ_ALLOC);
  assign bump_empty  = (bump_remaining == '0);
  assign bump_dec    = bump_remaining - BUMP_W'(1);
  assign do_push     = issue && (head.req.kind == REQ_FREE);
  assign do_list_pop = issue && is_alloc && bump_empty && list_nonempty;

  // Link store: push writes the old head, pop reads the successor
  always_ff @(posedge clk) begin
    if (do_push) begin
      link_mem[head.req.index] <= {list_nonempty, list_head};
    end
    if (do_list_pop) begin
      link_rdata <= link_mem[list_head];
    end
  end

  // Allocator state, sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      bump_remaining <= BUMP_W'(NUM_BLOCKS);
      list_head      <= '0;
      list_nonempty  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (issue) begin
            out_valid <= 1'b1;
            unique case (head.req.kind)
              REQ_FREE: begin
                list_head     <= head.req.index;
                list_nonempty <= 1'b1;
                block_index   <= head.req.index;
                status        <= STATUS_DONE;
              end
              REQ_IGNORE: begin
                block_index <= head.req.index;
                status      <= STATUS_DONE;
              end
              REQ_ALLOC: begin
                if (!bump_empty) begin
                  bump_remaining <= bump_dec;
                  block_index    <= bump_dec[IDX_W-1:0];
                  status         <= STATUS_DONE;
                end else if (list_nonempty) begin
                  block_index <= list_head;
                  status      <= STATUS_DONE;
                  state       <= ST_LINK;
                end else begin
                  block_index <= '0;
                  status      <= STATUS_FAILED;
                end
              end
              default: begin
                block_index <= head.req.index;
                status      <= STATUS_DONE;
              end
            endcase
          end
        end
        ST_LINK: begin
          // successor arrives from the link store in the cycle after the pop
          list_head     <= link_rdata[IDX_W-1:0];
          list_nonempty <= link_rdata[IDX_W];
          state         <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator.
// Input channel (in_valid/in_stall): op = 0 allocates a block, op = 1 returns
// free_index to the pool. Every item gives exactly one result on the output
// channel (out_valid/out_stall): block_index and status (1 = pool exhausted,
// block_index 0). A free echoes free_index with status 0.
// Allocation carves from a counter that runs down from the top of the pool,
// then pops a LIFO free list linked through a 256-entry link RAM.
// An accepted item is written into the front queue, then issues into the
// back result register.
// Throughput: one item per cycle while out_stall is low; an allocation served
// from the free list holds the back in ST_LINK while the successor
// is read from the link RAM (registered read port).
// A 2-entry queue parts the front from the back; in_stall rises only when it
// is full. When out_stall is high while out_valid is set, the result register
// holds, the back stops issuing and the queue fills, after which in_stall rises.
// Reset: all blocks uncarved, free list empty, queue and output empty. The
// link RAM needs no clearing, since only pushed entries are ever read.
module fixed_block_pool_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       op,
  input  logic [fbpa_pkg::IDX_W-1:0] free_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fbpa_pkg::IDX_W-1:0] block_index,
  output logic                       status
);
  import fbpa_pkg::*;

  queue_head_t head;
  logic        pop;

  fbpa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .free_index (free_index),
    .head       (head),
    .pop        (pop)
  );

  fbpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_index (block_index),
    .status      (status)
  );

endmodule

// File: sim/tb_top.sv
module tb_top;
  import fbpa_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int NUM_PHASES   = 5;
  localparam int NOISE_PHASE  = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int DIR_ROWS     = 22;

  // Sender idle and receiver stall odds (percent) per random phase
  localparam int IDLE_PCT  [NUM_PHASES] = '{0, 63, 0, 6, 25};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 63, 6, 25};

  typedef logic [IDX_W-1:0] blk_idx_t;

  typedef struct packed {
    blk_idx_t index;
    logic     status;
  } alloc_result_t;

  // One directed row: request, repeat count, and a typed result where obvious
  typedef struct packed {
    logic          op;
    blk_idx_t      index;
    logic [8:0]    reps;
    logic          typed;
    alloc_result_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     op = OP_ALLOC;
  blk_idx_t free_index = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  blk_idx_t block_index;
  logic     status;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Results still owed by the block, oldest first
  alloc_result_t pending_results[$];

  // Shadow pool: uncarved count, free-list head, link store
  logic [BUMP_W-1:0] uncarved;
  blk_idx_t          list_top;
  logic              list_live;
  logic [LINK_W-1:0] link_ram [LINK_DEPTH];
  bit                on_list [LINK_DEPTH];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd255, STATUS_DONE}},   // first carve: top block
    '{OP_ALLOC, 8'hFF, 9'd1,   1'b1, '{8'd254, STATUS_DONE}},
    '{OP_FREE,  8'hFF, 9'd1,   1'b1, '{8'd255, STATUS_DONE}},
    '{OP_FREE,  8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_DONE}},   // block not carved yet
    '{OP_ALLOC, 8'h00, 9'd253, 1'b0, '{8'd0,   STATUS_DONE}},   // carve down to 1
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_DONE}},   // last carve
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_DONE}},   // pop list head
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd255, STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_FAILED}}, // pool exhausted
    '{OP_ALLOC, 8'hFF, 9'd1,   1'b1, '{8'd0,   STATUS_FAILED}},
    '{OP_FREE,  8'h55, 9'd1,   1'b1, '{8'h55,  STATUS_DONE}},
    '{OP_FREE,  8'hAA, 9'd1,   1'b1, '{8'hAA,  STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'hAA,  STATUS_DONE}},
    '{OP_FREE,  8'hFF, 9'd1,   1'b1, '{8'hFF,  STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'hFF,  STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'h55,  STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_FAILED}},
    '{OP_FREE,  8'h80, 9'd1,   1'b0, '{8'd0,   STATUS_DONE}},
    '{OP_FREE,  8'h7F, 9'd1,   1'b0, '{8'd0,   STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b0, '{8'd0,   STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b0, '{8'd0,   STATUS_DONE}},
    '{OP_ALLOC, 8'h00, 9'd1,   1'b1, '{8'd0,   STATUS_FAILED}}
  };

  fixed_block_pool_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .free_index  (free_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_index (block_index),
    .status      (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow pool and return what the block must answer
  function automatic alloc_result_t pool_apply(logic req_op, blk_idx_t idx);
    alloc_result_t r;
    r.index  = idx;
    r.status = STATUS_DONE;
    if (req_op == OP_FREE) begin
      if (int'(idx) < NUM_BLOCKS) begin
        link_ram[idx] = {list_live, list_top};
        list_top      = idx;
        list_live     = 1'b1;
        on_list[idx]  = 1'b1;
      end
    end else if (uncarved != 0) begin
      uncarved = uncarved - 1'b1;
      r.index  = uncarved[IDX_W-1:0];
    end else if (list_live) begin
      r.index           = list_top;
      on_list[list_top] = 1'b0;
      {list_live, list_top} = link_ram[list_top];
    end else begin
      r.index  = '0;
      r.status = STATUS_FAILED;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Drive one item, hold it until taken, then maybe leave a gap
  task automatic send_request(logic req_op, blk_idx_t idx, logic typed, alloc_result_t want);
    alloc_result_t predicted;
    in_valid   <= 1'b1;
    op         <= req_op;
    free_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = pool_apply(req_op, idx);
    pending_results.push_back(typed ? want : predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, block_index", block_index, 0);
      end else begin
        want = pending_results.pop_front();
        if (block_index !== want.index) report_mismatch("block_index", block_index, want.index);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int       r;
    int       k;
    int       n;
    int       phase;
    int       start;
    int       cand;
    int       alloc_pct;
    logic     req_op;
    blk_idx_t idx;

    uncarved  = BUMP_W'(NUM_BLOCKS);
    list_top  = '0;
    list_live = 1'b0;
    for (k = 0; k < LINK_DEPTH; k++) on_list[k] = 1'b0;
    alloc_pct = 50;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: carve out, pop, exhaust, refill
    for (r = 0; r < DIR_ROWS; r++) begin
      for (k = 0; k < int'(dir_rows[r].reps); k++) begin
        send_request(dir_rows[r].op, dir_rows[r].index, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random phases; frees return owned blocks, last phase adds stray frees
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = IDLE_PCT[phase];
      recv_stall_pct = STALL_PCT[phase];
      for (n = 0; n < RANDOM_ITEMS; n++) begin
        if (n % 40 == 0) alloc_pct = $urandom_range(80, 20);
        req_op = OP_ALLOC;
        idx    = blk_idx_t'($urandom());
        if (phase == NOISE_PHASE && $urandom_range(99) < 30) begin
          req_op = OP_FREE;
        end else if ($urandom_range(99) >= alloc_pct) begin
          // pick a carved block that is not on the free list
          start = $urandom_range(LINK_DEPTH - 1);
          for (k = 0; k < LINK_DEPTH && req_op == OP_ALLOC; k++) begin
            cand = (start + k) % LINK_DEPTH;
            if (cand >= int'(uncarved) && !on_list[cand]) begin
              req_op = OP_FREE;
              idx    = cand[IDX_W-1:0];
            end
          end
        end
        send_request(req_op, idx, 1'b0, '0);
      end
      // hold off until the block has answered everything
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
